// ===== design/push_button_press_hold_detector_top_macros.svh =====
// Assertion macros for the push-button press/hold detector.
// Used by push_button_press_hold_detector_top; no other dependencies.
`ifndef PUSH_BUTTON_PRESS_HOLD_DETECTOR_TOP_MACROS_SVH
`define PUSH_BUTTON_PRESS_HOLD_DETECTOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define PBHD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbhd: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PBHD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbhd: next-cycle check failed");

`else

`define PBHD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PBHD_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/pbhd_pkg.sv =====
// Shared types and constants of the push-button press/hold detector.
// No dependencies; imported by pbhd_core and the top level.
`timescale 1ns / 1ps

package pbhd_pkg;

    // Field widths fixed by the interface.
    localparam int CNT_W   = 16;
    localparam int DUR_W   = 16;
    localparam int NOW_W   = 32;
    localparam int STATE_W = 3;
    localparam int CFG_IDX_W = 2;

    // Button state encoding as seen on the result fields.
    typedef enum logic [STATE_W-1:0] {
        ST_RELEASED = 3'd0,
        ST_PUSHED   = 3'd1,
        ST_HELD     = 3'd2,
        ST_PRESSED  = 3'd3,
        ST_UNKNOWN  = 3'd4
    } btn_state_t;

    // Input function codes.
    localparam logic FUNC_POLL  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PUSH_LEVEL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME     = 2'd2;

    // Configuration register set.
    typedef struct packed {
        logic             push_level;
        logic [DUR_W-1:0] debounce_time;
        logic [DUR_W-1:0] hold_time;
    } cfg_t;

    // One result transaction.
    typedef struct packed {
        btn_state_t       button_state;
        btn_state_t       prior_state;
        logic [CNT_W-1:0] hold_count;
        logic [CNT_W-1:0] press_count;
    } result_t;

endpackage

// ===== design/pbhd_core.sv =====
// Button state machine, one-shot timer and event counters.
// Depends on pbhd_pkg; instantiated by push_button_press_hold_detector_top.
`timescale 1ns / 1ps

module pbhd_core
    import pbhd_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 func,
    input  logic                 pin,
    input  logic [TIME_BITS-1:0] now,
    input  cfg_t                 cfg,
    output result_t              res_next
);

    btn_state_t             cur_state_reg, cur_state_next;
    btn_state_t             prev_state_reg, prev_state_next;
    logic                   last_pin_reg, last_pin_next;
    logic                   qual_reg, qual_next;
    logic                   hold_reg, hold_next;
    logic [TIME_BITS-1:0]   tmr_start_reg, tmr_start_next;
    logic [DUR_W-1:0]       tmr_len_reg, tmr_len_next;
    logic                   tmr_exp_reg, tmr_exp_next;
    logic [CNT_W-1:0]       holds_reg, holds_next;
    logic [CNT_W-1:0]       presses_reg, presses_next;

    logic [TIME_BITS-1:0]   elapsed;
    logic [TIME_BITS-1:0]   len_ext;
    logic                   exp_now;
    logic                   on;
    logic                   changed;

    // Timer test: wrapping elapsed time compared against the latched length.
    assign elapsed = now - tmr_start_reg;
    assign len_ext = {{(TIME_BITS-DUR_W){1'b0}}, tmr_len_reg};
    assign exp_now = tmr_exp_reg || (elapsed > len_ext);

    assign on      = (pin == cfg.push_level);
    assign changed = (pin != last_pin_reg);

    // Next-state logic for one poll or clear transaction.
    always_comb
    begin
        cur_state_next  = cur_state_reg;
        prev_state_next = prev_state_reg;
        last_pin_next   = last_pin_reg;
        qual_next       = qual_reg;
        hold_next       = hold_reg;
        tmr_start_next  = tmr_start_reg;
        tmr_len_next    = tmr_len_reg;
        tmr_exp_next    = tmr_exp_reg;
        holds_next      = holds_reg;
        presses_next    = presses_reg;

        if (func == FUNC_CLEAR)
        begin
            holds_next   = '0;
            presses_next = '0;
        end
        else
        begin
            cur_state_next = ST_UNKNOWN;
            if (on)
            begin
                if (changed)
                begin
                    // A fresh push restarts the timer with the debounce time.
                    tmr_start_next = now;
                    tmr_len_next   = cfg.debounce_time;
                    tmr_exp_next   = 1'b0;
                    qual_next      = 1'b0;
                    hold_next      = 1'b0;
                    cur_state_next = ST_PUSHED;
                end
                else if (cur_state_reg == ST_HELD)
                begin
                    cur_state_next = ST_PUSHED;
                end
                else if (cur_state_reg == ST_PUSHED)
                begin
                    if (!qual_reg)
                    begin
                        // Debounce done: qualify and start the hold timer.
                        if (exp_now)
                        begin
                            tmr_start_next = now;
                            tmr_len_next   = cfg.hold_time;
                            tmr_exp_next   = 1'b0;
                            qual_next      = 1'b1;
                        end
                        cur_state_next = ST_PUSHED;
                    end
                    else if (!hold_reg)
                    begin
                        tmr_exp_next = exp_now;
                        if (exp_now)
                        begin
                            hold_next      = 1'b1;
                            holds_next     = holds_reg + 1'b1;
                            cur_state_next = ST_HELD;
                        end
                        else
                        begin
                            cur_state_next = ST_PUSHED;
                        end
                    end
                end
            end
            else
            begin
                // A release after a qualified push without hold is a press.
                if (changed && qual_reg && !hold_reg)
                begin
                    presses_next   = presses_reg + 1'b1;
                    cur_state_next = ST_PRESSED;
                end
                else
                begin
                    cur_state_next = ST_RELEASED;
                end
            end
            last_pin_next   = pin;
            prev_state_next = cur_state_reg;
        end
    end

    // State registers, updated once per processed transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_state_reg  <= ST_RELEASED;
            prev_state_reg <= ST_RELEASED;
            last_pin_reg   <= 1'b1;
            qual_reg       <= 1'b0;
            hold_reg       <= 1'b0;
            tmr_start_reg  <= '0;
            tmr_len_reg    <= '0;
            tmr_exp_reg    <= 1'b0;
            holds_reg      <= '0;
            presses_reg    <= '0;
        end
        else if (step)
        begin
            cur_state_reg  <= cur_state_next;
            prev_state_reg <= prev_state_next;
            last_pin_reg   <= last_pin_next;
            qual_reg       <= qual_next;
            hold_reg       <= hold_next;
            tmr_start_reg  <= tmr_start_next;
            tmr_len_reg    <= tmr_len_next;
            tmr_exp_reg    <= tmr_exp_next;
            holds_reg      <= holds_next;
            presses_reg    <= presses_next;
        end
    end

    // The result reflects the state after this transaction.
    assign res_next.button_state = cur_state_next;
    assign res_next.prior_state  = prev_state_next;
    assign res_next.hold_count   = holds_next;
    assign res_next.press_count  = presses_next;

endmodule

// ===== design/push_button_press_hold_detector_top.sv =====
// A result is registered once its transaction leaves the input register.
// Throughput: one transaction per cycle while the result channel does not stall; the state machine
// steps as a transaction leaves the input register and the result register takes its new state.
// Reset clears all control and state registers, loads the configuration defaults
// (push level low, debounce 50 ms, hold 1000 ms) and leaves no result pending.
// Depends on pbhd_pkg, pbhd_core and push_button_press_hold_detector_top_macros.svh.
`timescale 1ns / 1ps
`include "push_button_press_hold_detector_top_macros.svh"

module push_button_press_hold_detector_top
    import pbhd_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DUR_W-1:0]     cfg_data,
    // Input channel.
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 func,
    input  logic                 pin_level,
    input  logic [NOW_W-1:0]     now_ms,
    // Result channel.
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATE_W-1:0]   button_state,
    output logic [STATE_W-1:0]   prior_state,
    output logic [CNT_W-1:0]     hold_count,
    output logic [CNT_W-1:0]     press_count
);

    cfg_t                   cfg_reg;
    logic                   s1_valid_reg;
    logic                   s1_func_reg;
    logic                   s1_pin_reg;
    logic [TIME_BITS-1:0]   s1_now_reg;
    logic                   out_valid_reg;
    result_t                out_res_reg;
    result_t                res_next;
    logic                   out_free;
    logic                   advance;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.push_level    <= 1'b0;
            cfg_reg.debounce_time <= 16'd50;
            cfg_reg.hold_time     <= 16'd1000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PUSH_LEVEL:    cfg_reg.push_level    <= cfg_data[0];
                CFG_DEBOUNCE_TIME: cfg_reg.debounce_time <= cfg_data;
                CFG_HOLD_TIME:     cfg_reg.hold_time     <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Pipeline control: the result register frees up when taken downstream.
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // The timestamp is fitted to the timer width as it loads.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_func_reg <= func;
            s1_pin_reg  <= pin_level;
            s1_now_reg  <= TIME_BITS'(now_ms);
        end
    end

    pbhd_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .func     (s1_func_reg),
        .pin      (s1_pin_reg),
        .now      (s1_now_reg),
        .cfg      (cfg_reg),
        .res_next (res_next)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign button_state = out_res_reg.button_state;
    assign prior_state  = out_res_reg.prior_state;
    assign hold_count   = out_res_reg.hold_count;
    assign press_count  = out_res_reg.press_count;

    // A waiting transaction moves into a free result register.
    `PBHD_ASSERT_NXT(a_advance_fills_out, clk, rst_n, advance, out_valid_reg)
    // Back pressure only while the input register is occupied.
    `PBHD_ASSERT_IMP(a_stall_needs_s1, clk, rst_n, !in_ready, s1_valid_reg && !out_free)
    // A clear transaction yields zero counters.
    `PBHD_ASSERT_NXT(a_clear_zeroes, clk, rst_n, advance && (s1_func_reg == FUNC_CLEAR),
        (hold_count == '0) && (press_count == '0))
    // A hold is only reported out of a pushed state.
    `PBHD_ASSERT_IMP(a_held_from_pushed, clk, rst_n,
        out_valid_reg && (out_res_reg.button_state == ST_HELD),
        out_res_reg.prior_state == ST_PUSHED)

endmodule

// ===== test/push_button_press_hold_detector_checker.sv =====
// Checker for the push-button press/hold detector: watches the configuration,
// input and result channels, predicts each result and compares it field by field.
// Depends on pbhd_pkg.
`timescale 1ns / 1ps

module push_button_press_hold_detector_checker
    import pbhd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DUR_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 func,
    input  logic                 pin_level,
    input  logic [NOW_W-1:0]     now_ms,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [STATE_W-1:0]   button_state,
    input  logic [STATE_W-1:0]   prior_state,
    input  logic [CNT_W-1:0]     hold_count,
    input  logic [CNT_W-1:0]     press_count,
    output int                   mismatch_count,
    output int                   results_owed
);

    // Mirror of the configuration registers.
    logic             lvl_push;
    logic [DUR_W-1:0] debounce_ms;
    logic [DUR_W-1:0] hold_ms;

    // Mirror of the detector state.
    btn_state_t       state_now;
    btn_state_t       state_before;
    logic             pin_last;
    logic             qualified;
    logic             hold_hit;
    logic [NOW_W-1:0] timer_origin;
    logic [DUR_W-1:0] timer_len;
    logic             timer_done;
    logic [CNT_W-1:0] holds_seen;
    logic [CNT_W-1:0] presses_seen;

    // Results predicted but not yet delivered, oldest first.
    result_t awaited_reports[$];

    // Restart the one-shot timer with a new length.
    task automatic arm_timer(input logic [DUR_W-1:0] len, input logic [NOW_W-1:0] t);
        timer_done   = 1'b0;
        timer_len    = len;
        timer_origin = t;
    endtask

    // The timer latches once the wrapped elapsed time exceeds its length.
    function automatic logic timer_ran_out(input logic [NOW_W-1:0] t);
        logic [NOW_W-1:0] elapsed;
        elapsed = t - timer_origin;
        if (!timer_done && elapsed > NOW_W'(timer_len))
            timer_done = 1'b1;
        return timer_done;
    endfunction

    // Step the button machine for one accepted transaction and queue its result.
    task automatic advance_button_machine(input logic f, input logic pin,
                                          input logic [NOW_W-1:0] t);
        btn_state_t nxt;
        logic       on;
        logic       changed;
        result_t    fresh;
        if (f == FUNC_CLEAR) begin
            holds_seen   = '0;
            presses_seen = '0;
        end else begin
            on      = (pin == lvl_push);
            changed = (pin != pin_last);
            nxt     = ST_UNKNOWN;
            if (on) begin
                if (changed) begin
                    arm_timer(debounce_ms, t);
                    qualified = 1'b0;
                    hold_hit  = 1'b0;
                    nxt       = ST_PUSHED;
                end else if (state_now == ST_HELD) begin
                    nxt = ST_PUSHED;
                end else if (state_now == ST_PUSHED) begin
                    if (!qualified) begin
                        if (timer_ran_out(t)) begin
                            arm_timer(hold_ms, t);
                            qualified = 1'b1;
                        end
                        nxt = ST_PUSHED;
                    end else if (!hold_hit) begin
                        if (timer_ran_out(t)) begin
                            hold_hit   = 1'b1;
                            holds_seen = holds_seen + 1'b1;
                            nxt        = ST_HELD;
                        end else begin
                            nxt = ST_PUSHED;
                        end
                    end
                end
            end else begin
                // A release only counts as a press after qualification without a hold.
                if (changed && qualified && !hold_hit) begin
                    presses_seen = presses_seen + 1'b1;
                    nxt          = ST_PRESSED;
                end else begin
                    nxt = ST_RELEASED;
                end
            end
            pin_last     = pin;
            state_before = state_now;
            state_now    = nxt;
        end
        fresh.button_state = state_now;
        fresh.prior_state  = state_before;
        fresh.hold_count   = holds_seen;
        fresh.press_count  = presses_seen;
        awaited_reports.push_back(fresh);
    endtask

    // Compare one result field and report a difference.
    task automatic check_field(input string label, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    // Follow every handshake on the three channels.
    always @(posedge clk or negedge rst_n) begin : watch
        result_t head;
        if (!rst_n) begin
            lvl_push       = 1'b0;
            debounce_ms    = DUR_W'(50);
            hold_ms        = DUR_W'(1000);
            state_now      = ST_RELEASED;
            state_before   = ST_RELEASED;
            pin_last       = 1'b1;
            qualified      = 1'b0;
            hold_hit       = 1'b0;
            timer_origin   = '0;
            timer_len      = '0;
            timer_done     = 1'b0;
            holds_seen     = '0;
            presses_seen   = '0;
            mismatch_count = 0;
            awaited_reports.delete();
            results_owed <= 0;
        end else begin
            // Register writes; the pin memory keeps its value across a new push level.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PUSH_LEVEL:    lvl_push    = cfg_data[0];
                    CFG_DEBOUNCE_TIME: debounce_ms = cfg_data;
                    CFG_HOLD_TIME:     hold_ms     = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                advance_button_machine(func, pin_level, now_ms);
            if (out_valid && out_ready) begin
                if (awaited_reports.size() == 0) begin
                    $display("%0t: unexpected result transaction, expected none, actual %0d",
                             $time, button_state);
                    mismatch_count++;
                end else begin
                    head = awaited_reports.pop_front();
                    check_field("button_state", head.button_state, button_state);
                    check_field("prior_state", head.prior_state, prior_state);
                    check_field("hold_count", head.hold_count, hold_count);
                    check_field("press_count", head.press_count, press_count);
                end
            end
            results_owed <= awaited_reports.size();
        end
    end

endmodule

// ===== test/push_button_press_hold_detector_top_test.sv =====
// Testbench top for the push-button press/hold detector: drives clock, reset,
// register writes, poll and clear transactions and result back-pressure, and gives the verdict.
// Depends on pbhd_pkg, the detector RTL and push_button_press_hold_detector_checker.
`timescale 1ns / 1ps

module push_button_press_hold_detector_top_test;
    import pbhd_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 88;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_PUSH_LEVEL;
    logic [DUR_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic                 func      = FUNC_POLL;
    logic                 pin_level = 1'b0;
    logic [NOW_W-1:0]     now_ms    = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [STATE_W-1:0]   button_state;
    logic [STATE_W-1:0]   prior_state;
    logic [CNT_W-1:0]     hold_count;
    logic [CNT_W-1:0]     press_count;

    int mismatch_count;
    int results_owed;

    // Stimulus bookkeeping.
    logic             cur_push   = 1'b0;
    int unsigned      cur_deb    = 50;
    int unsigned      cur_hold   = 1000;
    logic [NOW_W-1:0] clock_ms   = '0;
    int unsigned      items_sent = 0;
    int unsigned      burst_left = 0;

    // Receiver pacing.
    logic        hold_off_req  = 1'b0;
    logic        hold_off_done = 1'b0;
    int unsigned stall_left    = 0;
    int unsigned mode_left     = 0;
    int unsigned ready_mode    = 0;
    int unsigned cycle_count   = 0;

    push_button_press_hold_detector_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .pin_level    (pin_level),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .button_state (button_state),
        .prior_state  (prior_state),
        .hold_count   (hold_count),
        .press_count  (press_count)
    );

    push_button_press_hold_detector_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .pin_level      (pin_level),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .button_state   (button_state),
        .prior_state    (prior_state),
        .hold_count     (hold_count),
        .press_count    (press_count),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result back-pressure: changing stall patterns plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (hold_off_req && !hold_off_done) begin
            out_ready     <= 1'b0;
            stall_left    <= 150;
            hold_off_done <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                ready_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(16, 200);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ~out_ready;
            endcase
        end
    end

    // Offer one input transaction, in bursts separated by random gaps.
    task automatic send_item(input logic f, input logic pin, input logic [NOW_W-1:0] t);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        func      <= f;
        pin_level <= pin;
        now_ms    <= t;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Write one register once every outstanding result has arrived.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] data);
        in_valid <= 1'b0;
        while (results_owed != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Load the whole register set.
    task automatic apply_settings(input logic lvl, input int unsigned deb, input int unsigned hld);
        write_reg(CFG_PUSH_LEVEL, DUR_W'(lvl));
        write_reg(CFG_DEBOUNCE_TIME, DUR_W'(deb));
        write_reg(CFG_HOLD_TIME, DUR_W'(hld));
        cur_push = lvl;
        cur_deb  = deb;
        cur_hold = hld;
    endtask

    // One push and release, sized as a bounce, a short press or a long hold.
    task automatic play_gesture();
        int unsigned kind;
        int unsigned polls;
        int unsigned step_top;
        kind = $urandom_range(0, 2);
        case (kind)
            0: begin
                polls    = $urandom_range(1, 3);
                step_top = cur_deb / 3 + 1;
            end
            1: begin
                polls    = $urandom_range(2, 5);
                step_top = (cur_deb + cur_hold) / 4 + 1;
            end
            default: begin
                polls    = $urandom_range(3, 8);
                step_top = ((cur_deb > cur_hold) ? cur_deb : cur_hold) + 2;
            end
        endcase
        if ($urandom_range(0, 7) == 0)
            clock_ms = $urandom();
        send_item(FUNC_POLL, cur_push, clock_ms);
        repeat (polls) begin
            clock_ms += $urandom_range(step_top / 2, step_top);
            send_item(FUNC_POLL, cur_push, clock_ms);
        end
        repeat ($urandom_range(1, 3)) begin
            clock_ms += $urandom_range(1, 20);
            send_item(FUNC_POLL, ~cur_push, clock_ms);
        end
    endtask

    // Main stimulus sequence.
    initial
    begin
        int unsigned phase_end;
        int unsigned pick;
        int unsigned deb;
        int unsigned hld;
        logic        lvl;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Short press at the reset settings: bounce window, qualification, release.
        send_item(FUNC_POLL, 1'b1, 32'd0);
        send_item(FUNC_POLL, 1'b0, 32'd10);
        send_item(FUNC_POLL, 1'b0, 32'd40);
        send_item(FUNC_POLL, 1'b0, 32'd61);
        send_item(FUNC_POLL, 1'b1, 32'd100);
        send_item(FUNC_POLL, 1'b1, 32'd110);

        // Long hold: exact hold boundary, held once, then pushed and unknown.
        send_item(FUNC_POLL, 1'b0, 32'd200);
        send_item(FUNC_POLL, 1'b0, 32'd251);
        send_item(FUNC_POLL, 1'b0, 32'd1251);
        send_item(FUNC_POLL, 1'b0, 32'd1252);
        send_item(FUNC_POLL, 1'b0, 32'd1300);
        send_item(FUNC_POLL, 1'b0, 32'd1400);
        send_item(FUNC_POLL, 1'b1, 32'd1500);
        send_item(FUNC_CLEAR, 1'b0, 32'd0);

        // Timestamp wrap across zero during debounce, then a bounce.
        send_item(FUNC_POLL, 1'b0, 32'hFFFF_FFF0);
        send_item(FUNC_POLL, 1'b0, 32'h0000_0030);
        send_item(FUNC_POLL, 1'b1, 32'h0000_0040);
        send_item(FUNC_POLL, 1'b0, 32'h0000_0050);
        send_item(FUNC_POLL, 1'b1, 32'h0000_0060);
        send_item(FUNC_CLEAR, 1'b1, 32'hFFFF_FFFF);

        // New push level with the pin unchanged reads as unknown.
        apply_settings(1'b1, 50, 1000);
        send_item(FUNC_POLL, 1'b1, 32'h0000_0100);
        send_item(FUNC_POLL, 1'b0, 32'h0000_0110);
        send_item(FUNC_POLL, 1'b1, 32'h0000_0120);
        clock_ms = 32'h0000_1000;

        // Random phases, each with its own settings.
        for (int phase = 0; phase < PHASES; phase++) begin
            lvl = 1'($urandom_range(0, 1));
            deb = $urandom_range(0, 40);
            hld = $urandom_range(0, 120);
            if ($urandom_range(0, 3) == 0)
                deb = $urandom_range(0, 65535);
            if ($urandom_range(0, 3) == 0)
                hld = $urandom_range(0, 65535);
            if (phase == 0) begin
                lvl = 1'b1;
                deb = 0;
                hld = 0;
            end else if (phase == 1) begin
                lvl = 1'b0;
                deb = 65535;
                hld = 65535;
            end
            apply_settings(lvl, deb, hld);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                // Midway through one phase the receiver stops for a long stretch.
                if (phase == 3 && items_sent + 50 > phase_end)
                    hold_off_req <= 1'b1;
                pick = $urandom_range(0, 19);
                if (pick < 14)
                    play_gesture();
                else if (pick < 17)
                    send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
                else
                    send_item(FUNC_CLEAR, 1'($urandom_range(0, 1)), $urandom());
            end
        end
        in_valid <= 1'b0;

        // Drain the pipeline and give the verdict; the checker registers its count of owed
        // results at the edge that accepts the last transaction.
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
